>>> sv/dqvm_pkg.sv
package dqvm_pkg;

  localparam int MAX_WIDTH_DEF  = 512;
  localparam int MAX_HEIGHT_DEF = 512;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [9:0]  FRAME_WIDTH_RST    = 10'd512;
  localparam logic [9:0]  FRAME_HEIGHT_RST   = 10'd424;
  localparam logic [10:0] COLOR_LIMIT_X_RST  = 11'd1920;
  localparam logic [10:0] COLOR_LIMIT_Y_RST  = 11'd1080;
  localparam logic [15:0] EDGE_THRESHOLD_RST = 16'd50;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FRAME_WIDTH    = 3'd0,
    REG_FRAME_HEIGHT   = 3'd1,
    REG_COLOR_LIMIT_X  = 3'd2,
    REG_COLOR_LIMIT_Y  = 3'd3,
    REG_EDGE_THRESHOLD = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0]        depth_value;
    logic signed [15:0] color_x;
    logic signed [15:0] color_y;
    logic               frame_start;
  } pix_word_t;

  typedef struct packed {
    logic       quad_valid;
    logic [8:0] quad_row;
    logic [8:0] quad_col;
  } quad_word_t;

  typedef struct packed {
    logic [15:0] depth;
    logic        good;
  } line_entry_t;

  // Position of the current pixel and whether it closes a quad.
  typedef struct packed {
    logic       emit;
    logic [8:0] quad_row;
    logic [8:0] quad_col;
  } quad_pos_t;

  // Coordinate with 4 fractional bits inside [0, limit).
  function automatic logic coord_inside(logic signed [15:0] v, logic [10:0] limit);
    return !v[15] && (v[14:0] < {limit, 4'b0000});
  endfunction

  function automatic logic [15:0] abs_diff(logic [15:0] a, logic [15:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

>>> sv/depth_quad_validity_mask_top.sv
// Channel  Signals                          Word
// pixel    pix_valid, pix_stall, pix_data   depth, colour x/y, frame start
// result   res_valid, res_stall, res_data   quad flag, quad row, quad col
// config   cfg_write, cfg_index, cfg_data   one register per write
//
// One pixel per cycle sustained while the result side is not stalled.
// The line buffer read and write share the accept edge; the quad check runs
// in the stage after it, then the result register.
// Reset clears config, position, window and handshake state; line buffer is not cleared.
// A stalled result stalls the pixel side only once the check stage is full too.
module depth_quad_validity_mask_top #(
  parameter int MAX_WIDTH  = dqvm_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = dqvm_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 pix_valid,
  output logic                                 pix_stall,
  input  dqvm_pkg::pix_word_t                  pix_data,
  output logic                                 res_valid,
  input  logic                                 res_stall,
  output dqvm_pkg::quad_word_t                 res_data,
  input  logic                                 cfg_write,
  input  logic [dqvm_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [dqvm_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import dqvm_pkg::*;

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic [9:0]  frame_width;
  logic [9:0]  frame_height;
  logic [10:0] color_limit_x;
  logic [10:0] color_limit_y;
  logic [15:0] edge_threshold;

  logic          pix_accept;
  logic          eval_ready;
  logic [CW-1:0] pos_col;
  quad_pos_t     pos;
  line_entry_t   wr_entry, top_right;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width    <= FRAME_WIDTH_RST;
      frame_height   <= FRAME_HEIGHT_RST;
      color_limit_x  <= COLOR_LIMIT_X_RST;
      color_limit_y  <= COLOR_LIMIT_Y_RST;
      edge_threshold <= EDGE_THRESHOLD_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FRAME_WIDTH:    frame_width    <= cfg_data[9:0];
        REG_FRAME_HEIGHT:   frame_height   <= cfg_data[9:0];
        REG_COLOR_LIMIT_X:  color_limit_x  <= cfg_data[10:0];
        REG_COLOR_LIMIT_Y:  color_limit_y  <= cfg_data[10:0];
        REG_EDGE_THRESHOLD: edge_threshold <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign pix_stall  = !eval_ready;
  assign pix_accept = pix_valid && !pix_stall;

  assign wr_entry.depth = pix_data.depth_value;
  assign wr_entry.good  = (pix_data.depth_value != 16'd0) &&
                          coord_inside(pix_data.color_x, color_limit_x) &&
                          coord_inside(pix_data.color_y, color_limit_y);

  dqvm_position #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_position (
    .clk          (clk),
    .rst          (rst),
    .advance      (pix_accept),
    .frame_start  (pix_data.frame_start),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .col          (pos_col),
    .pos          (pos)
  );

  dqvm_line_buffer #(
    .DEPTH (MAX_WIDTH)
  ) u_line_buffer (
    .clk     (clk),
    .en      (pix_accept),
    .addr    (pos_col),
    .wr_data (wr_entry),
    .rd_data (top_right)
  );

  dqvm_quad_eval u_quad_eval (
    .clk            (clk),
    .rst            (rst),
    .load           (pix_accept),
    .pos            (pos),
    .depth          (pix_data.depth_value),
    .good           (wr_entry.good),
    .top_right      (top_right),
    .edge_threshold (edge_threshold),
    .ready          (eval_ready),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .res_data       (res_data)
  );

  // the pixel side backs up only behind a full, stalled result register
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    pix_stall |-> (res_valid && res_stall))
    else $error("pixel stall without a held result");

  // the first pixel of a frame never closes a quad
  a_frame_start_no_quad: assert property (@(posedge clk) disable iff (rst)
    (pix_accept && pix_data.frame_start) |-> !pos.emit)
    else $error("quad emitted at frame start");

  // back-to-back pixels inside a row step the column by one
  a_column_step: assert property (@(posedge clk) disable iff (rst)
    (pix_accept && $past(pix_accept) && !pix_data.frame_start && (pos_col != '0))
      |-> (pos_col == CW'($past(pos_col) + 1'b1)))
    else $error("column did not advance by one");

endmodule

>>> sv/dqvm_position.sv
module dqvm_position #(
  parameter int MAX_WIDTH  = dqvm_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = dqvm_pkg::MAX_HEIGHT_DEF,
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic                frame_start,
  input  logic [9:0]          frame_width,
  input  logic [9:0]          frame_height,
  output logic [CW-1:0]       col,
  output dqvm_pkg::quad_pos_t pos
);
  import dqvm_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  logic [CW-1:0] column_count, column_count_next;
  logic [RW-1:0] row_count, row_count_next;
  logic [WW-1:0] w_lim;
  logic [HW-1:0] h_lim;
  logic [CW-1:0] col_s, col_a;
  logic [RW-1:0] row_s, row_c;
  logic [HW-1:0] row_a, row_n;
  logic [WW-1:0] col_n;

  always_comb begin
    if (frame_width < 10'd2) begin
      w_lim = WW'(2);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      w_lim = WW'(MAX_WIDTH);
    end else begin
      w_lim = WW'(frame_width);
    end
    if (frame_height < 10'd2) begin
      h_lim = HW'(2);
    end else if (32'(frame_height) > MAX_HEIGHT) begin
      h_lim = HW'(MAX_HEIGHT);
    end else begin
      h_lim = HW'(frame_height);
    end
  end

  always_comb begin
    col_s = frame_start ? '0 : column_count;
    row_s = frame_start ? '0 : row_count;
    row_a = HW'(row_s);
    col_a = col_s;
    // a column left over from a wider frame starts the next row
    if (WW'(col_s) >= w_lim) begin
      col_a = '0;
      row_a = row_a + 1'b1;
    end
    if (row_a >= h_lim) begin
      row_a = '0;
    end
    row_c = RW'(row_a);

    col_n = WW'(col_a) + 1'b1;
    row_n = HW'(row_c);
    if (col_n >= w_lim) begin
      column_count_next = '0;
      row_n = row_n + 1'b1;
      if (row_n >= h_lim) begin
        row_n = '0;
      end
    end else begin
      column_count_next = CW'(col_n);
    end
    row_count_next = RW'(row_n);
  end

  assign col          = col_a;
  assign pos.emit     = (row_c != '0) && (col_a != '0);
  assign pos.quad_row = 9'(row_c - RW'(1));
  assign pos.quad_col = 9'(col_a - CW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (advance) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

endmodule

>>> sv/dqvm_line_buffer.sv
module dqvm_line_buffer #(
  parameter int DEPTH = dqvm_pkg::MAX_WIDTH_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [AW-1:0]         addr,
  input  dqvm_pkg::line_entry_t wr_data,
  output dqvm_pkg::line_entry_t rd_data
);
  import dqvm_pkg::*;

  line_entry_t mem [DEPTH];

  // read the previous row's entry, then replace it with the current pixel
  always_ff @(posedge clk) begin
    if (en) begin
      rd_data   <= mem[addr];
      mem[addr] <= wr_data;
    end
  end

endmodule

>>> sv/dqvm_quad_eval.sv
module dqvm_quad_eval (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  dqvm_pkg::quad_pos_t   pos,
  input  logic [15:0]           depth,
  input  logic                  good,
  input  dqvm_pkg::line_entry_t top_right,
  input  logic [15:0]           edge_threshold,
  output logic                  ready,
  output logic                  res_valid,
  input  logic                  res_stall,
  output dqvm_pkg::quad_word_t  res_data
);
  import dqvm_pkg::*;

  logic        s1_valid;
  quad_pos_t   s1_pos;
  logic [15:0] s1_depth;
  logic        s1_good;

  logic [15:0] left_depth;
  logic        left_valid;
  logic [15:0] upper_left_depth;
  logic        upper_left_valid;

  logic out_free, out_load, s1_done, ok;

  always_comb begin
    ok = upper_left_valid && top_right.good && left_valid && s1_good &&
         (abs_diff(upper_left_depth, top_right.depth) < edge_threshold) &&
         (abs_diff(top_right.depth, s1_depth) < edge_threshold) &&
         (abs_diff(s1_depth, left_depth) < edge_threshold);
  end

  assign out_free = !res_valid || !res_stall;
  assign out_load = s1_valid && s1_pos.emit && out_free;
  assign s1_done  = s1_valid && (!s1_pos.emit || out_free);
  assign ready    = !s1_valid || s1_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (load) begin
      s1_valid <= 1'b1;
    end else if (s1_done) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_pos   <= pos;
      s1_depth <= depth;
      s1_good  <= good;
    end
  end

  // advance the 2x2 window once the pixel leaves this stage
  always_ff @(posedge clk) begin
    if (rst) begin
      left_depth       <= '0;
      left_valid       <= 1'b0;
      upper_left_depth <= '0;
      upper_left_valid <= 1'b0;
    end else if (s1_done) begin
      left_depth       <= s1_depth;
      left_valid       <= s1_good;
      upper_left_depth <= top_right.depth;
      upper_left_valid <= top_right.good;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res_data.quad_valid <= ok;
      res_data.quad_row   <= s1_pos.quad_row;
      res_data.quad_col   <= s1_pos.quad_col;
    end
  end

endmodule

>>> test/quad_flag_checker.sv
module quad_flag_checker #(
  parameter int MAX_WIDTH  = dqvm_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = dqvm_pkg::MAX_HEIGHT_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             pix_valid,
  input  logic                             pix_stall,
  input  dqvm_pkg::pix_word_t              pix_data,
  input  logic                             res_valid,
  input  logic                             res_stall,
  input  dqvm_pkg::quad_word_t             res_data,
  input  logic                             cfg_write,
  input  logic [dqvm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dqvm_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                               errors,
  output int                               pending,
  output int                               quads_checked,
  output int                               quads_passed
);
  timeunit 1ns;
  timeprecision 1ps;

  import dqvm_pkg::*;

  localparam int PRINT_CAP = 100;

  // Register copies.
  logic [9:0]  frame_width;
  logic [9:0]  frame_height;
  logic [10:0] color_limit_x;
  logic [10:0] color_limit_y;
  logic [15:0] edge_threshold;

  // Raster position and 2x2 window.
  int          col;
  int          row;
  logic [15:0] prev_row_depth [MAX_WIDTH];
  logic        prev_row_good  [MAX_WIDTH];
  logic [15:0] left_depth;
  logic        left_good;
  logic [15:0] upper_left_depth;
  logic        upper_left_good;

  quad_word_t  expected_quads[$];

  initial begin
    errors = 0;
    pending = 0;
    quads_checked = 0;
    quads_passed = 0;
  end

  function automatic int span(input logic [9:0] v, input int hi);
    if (v < 2) return 2;
    if (int'(v) > hi) return hi;
    return int'(v);
  endfunction

  // Signed coordinate with 4 fractional bits against a whole-pixel bound.
  function automatic logic lands_inside(input logic signed [15:0] v, input logic [10:0] lim);
    int vi;
    vi = v;
    return (vi >= 0) && (vi < int'(lim) * 16);
  endfunction

  function automatic int depth_gap(input logic [15:0] a, input logic [15:0] b);
    int d;
    d = int'(a) - int'(b);
    return (d < 0) ? -d : d;
  endfunction

  task automatic flag_error(input string what);
    if (errors < PRINT_CAP) $display("[%0t] quad check: %s", $time, what);
    errors++;
  endtask

  task automatic clear_state();
    frame_width = FRAME_WIDTH_RST;
    frame_height = FRAME_HEIGHT_RST;
    color_limit_x = COLOR_LIMIT_X_RST;
    color_limit_y = COLOR_LIMIT_Y_RST;
    edge_threshold = EDGE_THRESHOLD_RST;
    col = 0;
    row = 0;
    left_depth = '0;
    left_good = 1'b0;
    upper_left_depth = '0;
    upper_left_good = 1'b0;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      prev_row_depth[i] = '0;
      prev_row_good[i] = 1'b0;
    end
    expected_quads.delete();
  endtask

  task automatic apply_write(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    case (cfg_reg_t'(idx))
      REG_FRAME_WIDTH:    frame_width = val[9:0];
      REG_FRAME_HEIGHT:   frame_height = val[9:0];
      REG_COLOR_LIMIT_X:  color_limit_x = val[10:0];
      REG_COLOR_LIMIT_Y:  color_limit_y = val[10:0];
      REG_EDGE_THRESHOLD: edge_threshold = val[15:0];
      default: ;
    endcase
  endtask

  task automatic predict_quad(input pix_word_t p);
    int          w;
    int          h;
    int          thr;
    logic        good;
    logic [15:0] top_right_depth;
    logic        top_right_good;
    quad_word_t  q;
    w = span(frame_width, MAX_WIDTH);
    h = span(frame_height, MAX_HEIGHT);
    thr = int'(edge_threshold);
    if (p.frame_start) begin
      col = 0;
      row = 0;
    end
    // A width or height shrunk under the current position moves it on.
    if (col >= w) begin
      col = 0;
      row++;
    end
    if (row >= h) row = 0;
    good = (p.depth_value != 0) && lands_inside(p.color_x, color_limit_x) &&
           lands_inside(p.color_y, color_limit_y);
    top_right_depth = prev_row_depth[col];
    top_right_good = prev_row_good[col];
    if (row >= 1 && col >= 1) begin
      // Left edge (upper left to left) stays unchecked.
      q.quad_valid = upper_left_good && top_right_good && left_good && good &&
                     depth_gap(upper_left_depth, top_right_depth) < thr &&
                     depth_gap(top_right_depth, p.depth_value) < thr &&
                     depth_gap(p.depth_value, left_depth) < thr;
      q.quad_row = 9'(row - 1);
      q.quad_col = 9'(col - 1);
      expected_quads.push_back(q);
    end
    prev_row_depth[col] = p.depth_value;
    prev_row_good[col] = good;
    upper_left_depth = top_right_depth;
    upper_left_good = top_right_good;
    left_depth = p.depth_value;
    left_good = good;
    col++;
    if (col >= w) begin
      col = 0;
      row++;
      if (row >= h) row = 0;
    end
  endtask

  task automatic compare_quad(input quad_word_t got);
    quad_word_t want;
    if (expected_quads.size() == 0) begin
      flag_error($sformatf("quad row %0d col %0d arrived with nothing outstanding",
                           got.quad_row, got.quad_col));
      return;
    end
    want = expected_quads.pop_front();
    quads_checked++;
    if (want.quad_valid) quads_passed++;
    if (got.quad_valid !== want.quad_valid)
      flag_error($sformatf("quad (%0d,%0d) flag %b, want %b",
                           want.quad_row, want.quad_col, got.quad_valid, want.quad_valid));
    if (got.quad_row !== want.quad_row)
      flag_error($sformatf("quad row %0d, want %0d", got.quad_row, want.quad_row));
    if (got.quad_col !== want.quad_col)
      flag_error($sformatf("quad col %0d, want %0d", got.quad_col, want.quad_col));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_state();
    end else begin
      if (cfg_write) apply_write(cfg_index, cfg_data);
      if (pix_valid && !pix_stall) predict_quad(pix_data);
      if (res_valid && !res_stall) compare_quad(res_data);
    end
    pending = expected_quads.size();
  end

endmodule

>>> test/tb_depth_quad_validity_mask_top.sv
module tb_depth_quad_validity_mask_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dqvm_pkg::*;

  localparam int RANDOM_ITEMS  = 500;
  localparam int SETTLE_CYCLES = 8;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   pix_valid = 1'b0;
  logic                   pix_stall;
  pix_word_t              pix_data = '0;
  logic                   res_valid;
  logic                   res_stall = 1'b0;
  quad_word_t             res_data;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int errors;
  int pending;
  int quads_checked;
  int quads_passed;

  // Stimulus shaping state.
  logic        quiet = 1'b0;
  logic        fs_noise = 1'b1;
  logic [15:0] surface = 16'd1000;
  logic [10:0] cur_lx = COLOR_LIMIT_X_RST;
  logic [10:0] cur_ly = COLOR_LIMIT_Y_RST;
  logic [15:0] cur_thr = EDGE_THRESHOLD_RST;
  int          stall_run = 0;
  int          pixels_sent = 0;
  int          settings = 0;

  depth_quad_validity_mask_top dut (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix_data  (pix_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  quad_flag_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .pix_valid     (pix_valid),
    .pix_stall     (pix_stall),
    .pix_data      (pix_data),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .res_data      (res_data),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .errors        (errors),
    .pending       (pending),
    .quads_checked (quads_checked),
    .quads_passed  (quads_passed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result-side stall bursts.
  always @(negedge clk) begin
    if (stall_run > 0) begin
      stall_run--;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      stall_run = $urandom_range(1, 15);
    end
    res_stall <= (stall_run > 0);
  end

  function automatic pix_word_t px(input int d, input int x, input int y, input logic fs);
    pix_word_t p;
    p.depth_value = 16'(d);
    p.color_x = 16'(x);
    p.color_y = 16'(y);
    p.frame_start = fs;
    return p;
  endfunction

  function automatic logic [15:0] coord_on_image(input logic [10:0] lim);
    if (lim == 0) return 16'($urandom);
    return 16'($urandom_range(0, int'(lim) * 16 - 1));
  endfunction

  // Mostly a smooth surface seen inside the image; the rest is holes and noise.
  function automatic pix_word_t make_pixel(input logic first);
    pix_word_t p;
    int        jitter;
    int        kind;
    kind = $urandom_range(0, 15);
    jitter = (int'(cur_thr) / 2 > 4000) ? 4000 : int'(cur_thr) / 2;
    p.depth_value = 16'(int'(surface) + $urandom_range(0, jitter));
    p.color_x = coord_on_image(cur_lx);
    p.color_y = coord_on_image(cur_ly);
    p.frame_start = first || (fs_noise && $urandom_range(0, 127) == 0);
    case (kind)
      0: p.depth_value = '0;
      1: p.color_x = 16'($urandom);
      2: p.color_y = 16'($urandom);
      3: begin
        p.depth_value = 16'($urandom);
        p.color_x = 16'($urandom);
        p.color_y = 16'($urandom);
      end
      default: ;
    endcase
    return p;
  endfunction

  // Enter at a falling edge; leave at the falling edge after the word is taken.
  task automatic send_pix(input pix_word_t w);
    int gap;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 15);
      pix_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix_valid <= 1'b1;
    pix_data <= w;
    @(posedge clk);
    while (pix_stall) @(posedge clk);
    @(negedge clk);
    pixels_sent++;
  endtask

  // Drop valid and wait out every outstanding quad plus the pipeline tail.
  task automatic settle();
    pix_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic load_setup(input logic [9:0] w, input logic [9:0] h, input logic [10:0] lx,
                            input logic [10:0] ly, input logic [15:0] thr);
    cfg_write <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data <= CFG_DATA_W'(w);
    @(negedge clk);
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_data <= CFG_DATA_W'(h);
    @(negedge clk);
    cfg_index <= REG_COLOR_LIMIT_X;
    cfg_data <= CFG_DATA_W'(lx);
    @(negedge clk);
    cfg_index <= REG_COLOR_LIMIT_Y;
    cfg_data <= CFG_DATA_W'(ly);
    @(negedge clk);
    cfg_index <= REG_EDGE_THRESHOLD;
    cfg_data <= thr;
    @(negedge clk);
    cfg_write <= 1'b0;
    cur_lx = lx;
    cur_ly = ly;
    cur_thr = thr;
    settings++;
  endtask

  initial begin
    int   n;
    int   ph;
    int   w;
    int   h;
    int   random_sent;
    logic fresh;
    random_sent = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: 3x3 frames, colour bound 1600 x 800, threshold 500.
    settle();
    load_setup(3, 3, 100, 50, 500);
    send_pix(px(1000, 0, 0, 1'b1));
    send_pix(px(1300, 1599, 799, 1'b0));
    send_pix(px(65535, 32767, 32767, 1'b0));
    send_pix(px(1700, 16, 16, 1'b0));
    send_pix(px(1600, 800, 400, 1'b0));        // only the unchecked left edge is wide
    send_pix(px(1650, 1600, 0, 1'b0));         // x on the exclusive bound
    send_pix(px(0, 0, 0, 1'b0));               // no measurement
    send_pix(px(1700, -1, 0, 1'b0));
    send_pix(px(1650, 0, 800, 1'b0));          // y on the exclusive bound
    send_pix(px(500, -32768, -32768, 1'b0));   // wraps to a new frame by itself
    send_pix(px(1000, 0, 0, 1'b0));
    send_pix(px(1499, 0, 0, 1'b0));
    send_pix(px(500, 0, 0, 1'b0));
    send_pix(px(1000, 0, 0, 1'b0));
    send_pix(px(1499, 0, 0, 1'b0));            // differences one under the threshold
    send_pix(px(100, 0, 0, 1'b1));
    send_pix(px(600, 0, 0, 1'b0));
    send_pix(px(100, 0, 0, 1'b0));
    send_pix(px(100, 0, 0, 1'b0));
    send_pix(px(100, 0, 0, 1'b0));             // top edge exactly at the threshold
    send_pix(px(1, 0, 0, 1'b0));

    ph = 0;
    while (random_sent < RANDOM_ITEMS) begin
      settle();
      fresh = 1'b1;
      fs_noise = 1'b1;
      surface = 16'($urandom_range(1, 60000));
      case (ph)
        0: begin
          load_setup(0, 0, 2047, 2047, 16'hFFFF);   // sizes below range act as 2
          n = 12;
        end
        1: begin
          load_setup(1, 1023, 0, 1080, 200);        // no x passes
          n = 40;
        end
        2: begin
          load_setup(6, 4, 1920, 1080, 0);          // no difference passes
          n = 30;
        end
        3: begin
          load_setup(7, 3, 1, 0, 300);
          n = 25;
        end
        4: begin
          // Stop at row 3, column 8 for the shrink steps that follow.
          fs_noise = 1'b0;
          load_setup(12, 6, 640, 480, 100);
          n = 44;
        end
        5: begin
          fresh = 1'b0;
          fs_noise = 1'b0;
          load_setup(5, 6, 640, 480, 100);          // width under the current column
          n = 8;
        end
        6: begin
          fresh = 1'b0;
          fs_noise = 1'b0;
          load_setup(5, 3, 640, 480, 100);          // height under the current row
          n = 20;
        end
        default: begin
          w = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 64) : $urandom_range(2, 16);
          h = $urandom_range(2, 8);
          load_setup(10'(w), 10'(h), 11'($urandom_range(40, 2047)),
                     11'($urandom_range(40, 2047)),
                     ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom_range(1, 3000)));
          n = w * h + $urandom_range(0, 2 * w);
        end
      endcase
      for (int i = 0; i < n; i++) send_pix(make_pixel(fresh && i == 0));
      random_sent += n;
      ph++;
    end

    // Last: a small frame and one row more, sent back to back, no idling.
    quiet = 1'b1;
    settle();
    fs_noise = 1'b0;
    surface = 16'($urandom_range(1, 60000));
    w = $urandom_range(8, 24);
    load_setup(10'(w), 10'd3, 11'($urandom_range(1, 2047)), 11'($urandom_range(1, 2047)),
               16'd800);
    for (int i = 0; i < 4 * w; i++) send_pix(make_pixel(i == 0));
    settle();

    $display("run: %0d pixels under %0d register settings, incl. clamped sizes,",
             pixels_sent, settings);
    $display("  mid-frame shrink, zero limits/threshold; %0d quads checked, %0d valid",
             quads_checked, quads_passed);
    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout: %0d quads still outstanding", pending);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
